/* design/fwq_pkg.sv */
// fwq_pkg: shared types and constants of the futex wait-queue engine
// no dependencies
package fwq_pkg;

    localparam int Buckets    = 16;
    localparam int Ways       = 2;
    localparam int QueueDepth = 8;
    localparam int MaxResults = 8;
    localparam int NSlots     = Buckets * Ways;
    localparam int NStore     = NSlots * QueueDepth;
    localparam int SlotW      = (NSlots > 1) ? $clog2(NSlots) : 1;
    localparam int BucketW    = (Buckets > 1) ? $clog2(Buckets) : 1;
    localparam int WayW       = (Ways > 1) ? $clog2(Ways) : 1;
    localparam int HeadW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CountW     = $clog2(QueueDepth + 1);
    localparam int StoreW     = (NStore > 1) ? $clog2(NStore) : 1;

    localparam logic [63:0] MixC1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MixC2 = 64'h94d049bb133111eb;

    typedef enum logic [2:0] {
        ST_BLOCKED    = 3'd0,
        ST_MISMATCH   = 3'd1,
        ST_WOKEN      = 3'd2,
        ST_NONE       = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_QUEUE_FULL = 3'd5
    } t_status;

    // hash unit operations
    typedef enum logic [2:0] {
        HOP_XS30 = 3'd0,
        HOP_MUL1 = 3'd1,
        HOP_XS27 = 3'd2,
        HOP_MUL2 = 3'd3,
        HOP_XS31 = 3'd4
    } t_hop;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_HWAIT,
        S_SEARCH,
        S_DECIDE,
        S_RD,
        S_RDWAIT,
        S_EMIT,
        S_OUT
    } t_state;

endpackage

/* design/fwq_ram.sv */
// fwq_ram: generic single-port-write, registered-read ram
// no dependencies
module fwq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/fwq_hash.sv */
// fwq_hash: shared splitmix64 step unit, one xor-shift or 16-bit partial product a cycle
// depends on fwq_pkg
module fwq_hash (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_addr,
    output logic          o_done,
    output logic [63:0]   o_hash
);
    import fwq_pkg::*;

    logic        r_busy, n_busy;
    t_hop        r_op, n_op;
    logic [1:0]  r_part, n_part;
    logic [63:0] r_val, n_val;
    logic [63:0] r_acc, n_acc;
    logic [63:0] w_c;
    logic [63:0] w_pp;

    assign w_c   = (r_op == HOP_MUL1) ? MixC1 : MixC2;
    // one 64x16 partial product, truncated to 64 bits
    assign w_pp  = (r_val * {48'd0, w_c[r_part*16 +: 16]}) << (r_part * 16);
    // final xor-shift result is on n_val in the cycle o_done is high
    assign o_hash = n_val;

    // step sequencer
    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_part = r_part;
        n_val  = r_val;
        n_acc  = r_acc;
        o_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_op   = HOP_XS30;
            n_val  = i_addr;
        end else if (r_busy) begin
            case (r_op)
                HOP_XS30: begin
                    n_val = r_val ^ (r_val >> 30);
                    n_op  = HOP_MUL1;
                    n_part = 2'd0;
                    n_acc = '0;
                end
                HOP_MUL1, HOP_MUL2: begin
                    n_acc  = r_acc + w_pp;
                    n_part = r_part + 2'd1;
                    if (r_part == 2'd3) begin
                        n_val = r_acc + w_pp;
                        n_op  = (r_op == HOP_MUL1) ? HOP_XS27 : HOP_XS31;
                    end
                end
                HOP_XS27: begin
                    n_val  = r_val ^ (r_val >> 27);
                    n_op   = HOP_MUL2;
                    n_part = 2'd0;
                    n_acc  = '0;
                end
                HOP_XS31: begin
                    n_val  = r_val ^ (r_val >> 31);
                    n_busy = 1'b0;
                    o_done = 1'b1;
                end
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_op   <= n_op;
        r_part <= n_part;
        r_val  <= n_val;
        r_acc  <= n_acc;
    end
endmodule

/* design/futex_wait_queue_engine_core.sv */
// futex_wait_queue_engine_core: top level of the futex wait-queue engine
// depends on fwq_pkg, fwq_hash, fwq_ram
// steps: hashing, a key read, a search over the Ways (2) ways of the bucket and a decide step
// give a single result; a wake that releases tasks then reads and emits its tasks one by one
// throughput: one transaction at a time; o_s_tready is low until the last result is taken,
// then high in the cycle after
// reset: synchronous active low, clears slot valid bits, queue heads and counts
module futex_wait_queue_engine_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // address, expected_value, current_value, task_id, wake_count (lsb first)
    input  logic [207:0]  i_s_tdata,
    // op
    input  logic          i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // status, woken_task (lsb first), 5 zero pad bits
    output logic [15:0]   o_m_tdata,
    output logic          o_m_tlast
);
    import fwq_pkg::*;

    t_state r_state, n_state;

    logic               r_op;
    logic [63:0]        r_addr;
    logic               r_match;
    logic [7:0]         r_task;
    logic [7:0]         r_wcnt;
    logic [BucketW-1:0] r_bucket;
    logic [WayW:0]      r_way;
    logic               r_hit, r_has_free, r_has_empty;
    logic [WayW-1:0]    r_hit_way, r_free_way, r_empty_way;
    logic [3:0]         r_left;
    logic [2:0]         r_ostat;
    logic [7:0]         r_otask;
    logic               r_olast;
    logic               r_ovalid;
    logic [SlotW-1:0]   r_slot;

    logic [NSlots-1:0]  r_valid;
    logic [HeadW-1:0]   r_head  [NSlots];
    logic [CountW-1:0]  r_count [NSlots];

    logic               w_hdone;
    logic [63:0]        w_hash;
    logic [63:0]        w_key_rd;
    logic               w_key_we;
    logic [SlotW-1:0]   w_key_ra;
    logic               w_st_we;
    logic [StoreW-1:0]  w_st_wa, w_st_ra;
    logic [7:0]         w_st_rd;
    logic [SlotW-1:0]   w_cur_slot;
    logic [WayW-1:0]    w_way_idx;
    logic [HeadW-1:0]   w_tail;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_otask, r_ostat};
    assign o_m_tlast  = r_olast;

    assign w_way_idx  = r_way[WayW-1:0];
    assign w_cur_slot = SlotW'(r_bucket * Ways + w_way_idx);
    assign w_key_ra   = w_cur_slot;
    // a freshly claimed slot starts its queue at position 0
    assign w_tail     = w_key_we ? '0
                                 : HeadW'((r_head[r_slot] + r_count[r_slot]) % QueueDepth);
    assign w_st_wa    = StoreW'(r_slot * QueueDepth + w_tail);
    assign w_st_ra    = StoreW'(r_slot * QueueDepth + r_head[r_slot]);

    fwq_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_s_tvalid && o_s_tready),
        .i_addr  (i_s_tdata[63:0]),
        .o_done  (w_hdone),
        .o_hash  (w_hash)
    );

    fwq_ram #(.Width(64), .Depth(NSlots)) u_keys (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_slot),
        .i_wdata (r_addr),
        .i_raddr (w_key_ra),
        .o_rdata (w_key_rd)
    );

    fwq_ram #(.Width(8), .Depth(NStore)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_wa),
        .i_wdata (r_task),
        .i_raddr (w_st_ra),
        .o_rdata (w_st_rd)
    );

    // sequencer next state and strobes
    always_comb begin
        n_state  = r_state;
        w_key_we = 1'b0;
        w_st_we  = 1'b0;
        case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_HASH;
            S_HASH:   if (w_hdone) n_state = S_HWAIT;
            S_HWAIT:  n_state = S_SEARCH;
            S_SEARCH: if (r_way == (WayW + 1)'(Ways)) n_state = S_DECIDE;
            S_DECIDE: n_state = S_OUT;
            S_RD:     n_state = S_RDWAIT;
            S_RDWAIT: n_state = S_EMIT;
            S_EMIT:   n_state = S_OUT;
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = (r_olast) ? S_IDLE : S_RD;
                end
            end
            default:  n_state = S_IDLE;
        endcase
        if (r_state == S_DECIDE && !r_op && !r_hit && (r_has_free || r_has_empty)) begin
            w_key_we = 1'b1;
        end
        if (r_state == S_DECIDE && !r_op && (r_hit || r_has_free || r_has_empty)
                && r_match && (w_key_we || r_count[r_slot] < CountW'(QueueDepth))) begin
            w_st_we = 1'b1;
        end
        if (r_state == S_DECIDE && r_op && r_hit && r_count[r_slot] != '0 && r_wcnt != '0) begin
            n_state = S_RD;
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_valid  <= '0;
            for (int i = 0; i < NSlots; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op    <= i_s_tuser;
                        r_addr  <= i_s_tdata[63:0];
                        r_match <= (i_s_tdata[127:64] == i_s_tdata[191:128]);
                        r_task  <= i_s_tdata[199:192];
                        r_wcnt  <= i_s_tdata[207:200];
                    end
                end
                S_HASH: begin
                    r_bucket    <= BucketW'(w_hash % Buckets);
                    r_way       <= '0;
                    r_hit       <= 1'b0;
                    r_has_free  <= 1'b0;
                    r_has_empty <= 1'b0;
                end
                S_HWAIT: begin
                    r_way <= r_way + 1'b1;
                end
                S_SEARCH: begin
                    // key read for way r_way-1 is now on w_key_rd
                    if (r_way != (WayW + 1)'(Ways)) r_way <= r_way + 1'b1;
                    begin : search
                        logic [WayW-1:0] pw;
                        logic [SlotW-1:0] ps;
                        pw = WayW'(r_way - 1'b1);
                        ps = SlotW'(r_bucket * Ways + pw);
                        if (r_valid[ps]) begin
                            if (w_key_rd == r_addr && !r_hit) begin
                                r_hit <= 1'b1; r_hit_way <= pw;
                            end
                            if (r_count[ps] == '0 && !r_has_empty) begin
                                r_has_empty <= 1'b1; r_empty_way <= pw;
                            end
                        end else if (!r_has_free) begin
                            r_has_free <= 1'b1; r_free_way <= pw;
                        end
                        if (r_way == (WayW + 1)'(Ways)) begin
                            // resolve slot for decide stage
                            r_slot <= SlotW'(r_bucket * Ways + (
                                (r_hit || (r_valid[ps] && w_key_rd == r_addr))
                                    ? ((r_hit) ? r_hit_way : pw)
                                    : ((r_has_free || !r_valid[ps])
                                        ? ((r_has_free) ? r_free_way : pw)
                                        : ((r_has_empty) ? r_empty_way : pw))));
                        end
                    end
                end
                S_DECIDE: begin
                    // a wake that releases tasks shows nothing until its first read
                    r_ovalid <= (n_state != S_RD);
                    r_otask  <= '0;
                    r_olast  <= 1'b1;
                    if (!r_op) begin
                        if (!(r_hit || r_has_free || r_has_empty)) begin
                            r_ostat <= ST_TABLE_FULL;
                        end else begin
                            if (w_key_we) begin
                                r_valid[r_slot] <= 1'b1;
                                r_head[r_slot]  <= '0;
                            end
                            if (!r_match) begin
                                r_ostat <= ST_MISMATCH;
                                if (w_key_we) r_count[r_slot] <= '0;
                            end else if (!w_key_we && r_count[r_slot] >= CountW'(QueueDepth)) begin
                                r_ostat <= ST_QUEUE_FULL;
                            end else begin
                                r_ostat <= ST_BLOCKED;
                                r_count[r_slot] <= w_key_we ? CountW'(1)
                                                            : r_count[r_slot] + 1'b1;
                            end
                        end
                    end else if (n_state == S_RD) begin
                        begin : lim
                            logic [7:0] n;
                            n = 8'(r_count[r_slot]);
                            if (n > r_wcnt) n = r_wcnt;
                            if (n > 8'(MaxResults)) n = 8'(MaxResults);
                            r_left <= 4'(n);
                        end
                    end else begin
                        r_ostat <= ST_NONE;
                    end
                end
                S_EMIT: begin
                    r_ovalid <= 1'b1;
                    r_ostat  <= ST_WOKEN;
                    r_otask  <= w_st_rd;
                    r_olast  <= (r_left == 4'd1);
                    r_left   <= r_left - 1'b1;
                    r_head[r_slot]  <= HeadW'((r_head[r_slot] + 1'b1) % QueueDepth);
                    r_count[r_slot] <= r_count[r_slot] - 1'b1;
                end
                S_OUT: begin
                    if (i_m_tready) r_ovalid <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule
